// ===== sv/text_console_glyph_renderer_assert.svh =====
// Assertion macros for the text console glyph renderer checker.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// checked outside reset only
`define TCGR_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tcgr assertion failed");

// checked in every cycle, reset included
`define TCGR_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("tcgr assertion failed");

`endif

// ===== sv/tcgr_pkg.sv =====
// Shared types and constants of the text console glyph renderer.
// No dependencies; the design, checker and testbench files import it.
`timescale 1ns / 1ps

package tcgr_pkg;

   localparam int DEFAULT_GLYPH_COUNT = 256;
   localparam int MAX_DIMENSION       = 4096;

   localparam int CURSOR_W    = 13;
   localparam int COORD_W     = 14;
   localparam int PIX_W       = 12;
   localparam int CODE_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int CSR_INDEX_W = 2;

   localparam int TEXT_TOP = 72;
   localparam int CELL     = 8;

   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0a;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_COLOR    = 2'd2;

   localparam logic CMD_LOAD_ROW = 1'b0;
   localparam logic CMD_PUT_CHAR = 1'b1;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_NEWLINE,
      OP_CHAR
   } op_type;

   typedef struct packed {
      logic              command;
      logic [CODE_W-1:0] char_code;
      logic [2:0]        glyph_row;
      logic [7:0]        row_bits;
      logic              inverted;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic             last;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [CODE_W-1:0] glyph;
      logic [2:0]        glyph_row;
      logic [7:0]        row_bits;
      logic              inverted;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_head_type;

   typedef struct packed {
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [COLOR_W-1:0] color;
   } cfg_type;

endpackage

// ===== sv/tcgr_front.sv =====
// Front end: decodes each request into a work item and holds it in a short queue.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps

module tcgr_front #(
   parameter int GLYPH_COUNT = tcgr_pkg::DEFAULT_GLYPH_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcgr_pkg::req_type      req_payload,
   output tcgr_pkg::work_head_type head,
   input  logic                   pop
);
   import tcgr_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CODE_W:0] GLYPH_LIMIT = (CODE_W + 1)'(GLYPH_COUNT);

   work_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wptr_ff;
   logic [PTR_W-1:0]   rptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               push;
   logic [CODE_W:0]    code_wide;
   logic [CODE_W:0]    code_wrapped;
   work_type           decoded;

   always_comb begin
      code_wide    = {1'b0, req_payload.char_code};
      code_wrapped = (code_wide >= GLYPH_LIMIT) ? code_wide - GLYPH_LIMIT : code_wide;

      decoded.glyph     = code_wrapped[CODE_W-1:0];
      decoded.glyph_row = req_payload.glyph_row;
      decoded.row_bits  = req_payload.row_bits;
      decoded.inverted  = req_payload.inverted;
      priority if (req_payload.command == CMD_LOAD_ROW) begin
         decoded.op = OP_LOAD;
      end else if (req_payload.char_code == NEWLINE_CODE) begin
         decoded.op = OP_NEWLINE;
      end else begin
         decoded.op = OP_CHAR;
      end
   end

   assign req_stall  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head.valid = (count_ff != '0);
   assign head.work  = entries_ff[rptr_ff];
   assign count_in   = count_ff + COUNT_W'(push) - COUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/tcgr_back.sv =====
// Back end: font memory, text cursor and the glyph scan that issues pixel writes.
// Depends on tcgr_pkg; takes work items from tcgr_front.
`timescale 1ns / 1ps

module tcgr_back #(
   parameter int GLYPH_COUNT = tcgr_pkg::DEFAULT_GLYPH_COUNT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcgr_pkg::cfg_type       cfg,
   input  tcgr_pkg::work_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tcgr_pkg::rsp_type       rsp_payload
);
   import tcgr_pkg::*;

   localparam int GW = $clog2(GLYPH_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAW
   } state_type;

   logic [7:0][7:0] font_ram [GLYPH_COUNT];

   state_type           state_ff;
   logic [CURSOR_W-1:0] col_ff;
   logic [CURSOR_W-1:0] row_ff;
   logic [63:0]         rd_ff;
   logic [63:0]         mask_ff;
   logic [5:0]          pos_ff;
   logic                inv_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic               out_free;
   logic               rsp_load;
   logic               ram_we;
   logic               ram_re;
   logic [GW-1:0]      ram_addr;
   logic               scroll;
   logic               rest_empty;
   logic [2:0]         cur_r;
   logic [2:0]         cur_b;
   logic [COORD_W-1:0] px_raw;
   logic [COORD_W-1:0] py_raw;
   logic [COORD_W-1:0] px;
   logic [COORD_W-1:0] py;
   logic [COORD_W-1:0] next_col;
   rsp_type            pixel_rsp;
   rsp_type            scroll_rsp;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && head.valid && out_free;
   assign ram_we   = pop && (head.work.op == OP_LOAD);
   assign ram_re   = pop && (head.work.op == OP_CHAR);
   assign ram_addr = head.work.glyph[GW-1:0];
   assign rsp_load = (pop && (head.work.op == OP_NEWLINE) && scroll)
                  || ((state_ff == ST_DRAW) && out_free && mask_ff[0]);

   always_ff @(posedge clock) begin
      if (ram_we) begin
         font_ram[ram_addr][head.work.glyph_row] <= head.work.row_bits;
      end
      if (ram_re) begin
         rd_ff <= font_ram[ram_addr];
      end
   end

   always_comb begin
      cur_r      = pos_ff[5:3];
      cur_b      = pos_ff[2:0];
      rest_empty = (mask_ff[63:1] == '0);
      scroll     = ({1'b0, row_ff} + COORD_W'(TEXT_TOP + CELL)) > cfg.height;
      next_col   = {1'b0, col_ff} + COORD_W'(CELL);

      px_raw = {1'b0, col_ff} + COORD_W'(4'd8 - {1'b0, cur_b});
      py_raw = {1'b0, row_ff} + COORD_W'(TEXT_TOP) + COORD_W'(cur_r);
      px     = (px_raw >= cfg.width)  ? cfg.width  - 1'b1 : px_raw;
      py     = (py_raw >= cfg.height) ? cfg.height - 1'b1 : py_raw;

      pixel_rsp.kind    = KIND_PIXEL;
      pixel_rsp.pixel_x = px[PIX_W-1:0];
      pixel_rsp.pixel_y = py[PIX_W-1:0];
      pixel_rsp.red     = cfg.color[23:16];
      pixel_rsp.green   = cfg.color[15:8];
      pixel_rsp.blue    = cfg.color[7:0];
      pixel_rsp.last    = rest_empty;

      scroll_rsp         = '0;
      scroll_rsp.kind    = KIND_SCROLL;
      scroll_rsp.last    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  unique case (head.work.op)
                     OP_NEWLINE: begin
                        col_ff <= '0;
                        if (scroll) begin
                           rsp_data_ff  <= scroll_rsp;
                        end else begin
                           row_ff <= row_ff + CURSOR_W'(CELL);
                        end
                     end
                     OP_CHAR: begin
                        inv_ff   <= head.work.inverted;
                        state_ff <= ST_FETCH;
                     end
                     OP_LOAD: ;
                     default: ;
                  endcase
               end
            end
            ST_FETCH: begin
               mask_ff  <= inv_ff ? ~rd_ff : rd_ff;
               pos_ff   <= '0;
               state_ff <= ST_DRAW;
            end
            ST_DRAW: begin
               if (out_free) begin
                  if (mask_ff[0]) begin
                     rsp_data_ff  <= pixel_rsp;
                  end
                  mask_ff <= mask_ff >> 1;
                  pos_ff  <= pos_ff + 1'b1;
                  if (rest_empty) begin
                     state_ff <= ST_IDLE;
                     if (next_col > cfg.width) begin
                        col_ff <= '0;
                        row_ff <= row_ff + CURSOR_W'(CELL);
                     end else begin
                        col_ff <= next_col[CURSOR_W-1:0];
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== sv/text_console_glyph_renderer.sv =====
// Top level of the text console glyph renderer: control registers, front end and render engine.
// Depends on tcgr_pkg, tcgr_front and tcgr_back.
//
// Requests load one row of the 8x8 font or put one character at the text cursor; a character
// becomes one pixel write per drawn glyph bit, a newline near the bottom a scroll request.
// A font-row load and a newline are each done as the render engine takes them. A character
// reads its glyph from the font memory, passes the fetch state and then enters the glyph
// scan up to its last drawn bit. The scan examines one bit per cycle and feeds a single
// result register; result stalls hold the scan. A two-entry queue ahead of the engine takes
// further requests meanwhile. Control registers accept a write every cycle; the user must
// write them only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module text_console_glyph_renderer #(
   parameter int GLYPH_COUNT = tcgr_pkg::DEFAULT_GLYPH_COUNT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tcgr_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tcgr_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcgr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tcgr_pkg::COLOR_W-1:0]          csr_wdata
);
   import tcgr_pkg::*;

   logic [CURSOR_W-1:0] width_ff;
   logic [CURSOR_W-1:0] height_ff;
   logic [COLOR_W-1:0]  color_ff;
   cfg_type             cfg;
   work_head_type       head;
   logic                pop;

   function automatic logic [COORD_W-1:0] effective_dim(input logic [CURSOR_W-1:0] v);
      logic [COORD_W-1:0] wide;
      wide = {1'b0, v};
      priority if (v == '0) begin
         return COORD_W'(1);
      end else if (wide > COORD_W'(MAX_DIMENSION)) begin
         return COORD_W'(MAX_DIMENSION);
      end else begin
         return wide;
      end
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CURSOR_W'(640);
         height_ff <= CURSOR_W'(480);
         color_ff  <= 24'hffffff;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[CURSOR_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[CURSOR_W-1:0];
            CSR_DRAW_COLOR:    color_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.width  = effective_dim(width_ff);
   assign cfg.height = effective_dim(height_ff);
   assign cfg.color  = color_ff;

   tcgr_front #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .head       (head),
      .pop        (pop)
   );

   tcgr_back #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== sv/tcgr_checker.sv =====
// Port-level checks of the text console glyph renderer, bound to the top level.
// Depends on tcgr_pkg and text_console_glyph_renderer_assert.svh.
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tcgr_pkg::rsp_type rsp_payload
);
   import tcgr_pkg::*;

   `TCGR_ASSERT(rsp_held_while_stalled, (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload)))
   `TCGR_ASSERT(scroll_is_bare_and_last, (rsp_valid && rsp_payload.kind == KIND_SCROLL |-> rsp_payload.last && rsp_payload.pixel_x == '0 && rsp_payload.pixel_y == '0))
   `TCGR_ASSERT_ALWAYS(no_result_after_reset, (reset |=> !rsp_valid))
   `TCGR_ASSERT_ALWAYS(queue_open_after_reset, (reset |=> !req_stall))

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

// ===== dv/text_console_glyph_renderer_tb.sv =====
// Self-checking testbench for the text console glyph renderer: font loads, characters,
// newlines and scroll requests checked against an in-bench model of the console.
// Depends on tcgr_pkg and text_console_glyph_renderer.
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;
   import tcgr_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COLOR_W-1:0]     csr_wdata;

   // console model state
   logic [7:0]         font_rows [256][8];
   logic [7:0]         rows_loaded [256];
   logic [7:0]         ready_glyphs [$];
   logic [12:0]        col_pos;
   logic [12:0]        row_pos;
   logic [12:0]        cfg_width;
   logic [12:0]        cfg_height;
   logic [COLOR_W-1:0] cfg_color;
   rsp_type            queued_writes [$];

   int   failures = 0;
   int   hold_cycles = 0;
   logic steady = 1'b0;

   text_console_glyph_renderer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(10_000_000);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned screen_extent(input logic [12:0] v);
      if (v == 13'd0)
         return 1;
      if (v > MAX_DIMENSION)
         return MAX_DIMENSION;
      return 32'(v);
   endfunction

   function automatic void render_request(input req_type item);
      int unsigned w;
      int unsigned h;
      int unsigned px;
      int unsigned py;
      int unsigned nc;
      int          rr;
      int          bb;
      int          drawn;
      rsp_type     wr;
      w = screen_extent(cfg_width);
      h = screen_extent(cfg_height);
      drawn = 0;
      if (item.command == CMD_LOAD_ROW) begin
         font_rows[item.char_code][item.glyph_row] = item.row_bits;
         if (rows_loaded[item.char_code] != 8'hff) begin
            rows_loaded[item.char_code][item.glyph_row] = 1'b1;
            if (rows_loaded[item.char_code] == 8'hff)
               ready_glyphs.push_back(item.char_code);
         end
         return;
      end
      if (item.char_code == NEWLINE_CODE) begin
         col_pos = '0;
         if (row_pos + TEXT_TOP + CELL > h) begin
            wr = '0;
            wr.kind = KIND_SCROLL;
            wr.last = 1'b1;
            queued_writes.push_back(wr);
         end else begin
            row_pos = 13'(row_pos + CELL);
         end
         return;
      end
      for (rr = 0; rr < 8; rr++) begin
         for (bb = 0; bb < 8; bb++) begin
            if (font_rows[item.char_code][rr][bb] != item.inverted) begin
               px = col_pos + CELL - bb;
               if (px > w - 1)
                  px = w - 1;
               py = row_pos + TEXT_TOP + rr;
               if (py > h - 1)
                  py = h - 1;
               wr.kind = KIND_PIXEL;
               wr.pixel_x = px[PIX_W-1:0];
               wr.pixel_y = py[PIX_W-1:0];
               wr.red = cfg_color[23:16];
               wr.green = cfg_color[15:8];
               wr.blue = cfg_color[7:0];
               wr.last = 1'b0;
               queued_writes.push_back(wr);
               drawn++;
            end
         end
      end
      if (drawn > 0)
         queued_writes[queued_writes.size()-1].last = 1'b1;
      nc = col_pos + CELL;
      if (nc > w) begin
         col_pos = '0;
         row_pos = 13'(row_pos + CELL);
      end else begin
         col_pos = nc[12:0];
      end
   endfunction

   function automatic req_type build_request(input logic cmd, input logic [7:0] code,
                                             input logic [2:0] grow, input logic [7:0] bits,
                                             input logic inv);
      req_type item;
      item.command = cmd;
      item.char_code = code;
      item.glyph_row = grow;
      item.row_bits = bits;
      item.inverted = inv;
      return item;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : check_writes
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (queued_writes.size() == 0) begin
            $error("unexpected result: kind %0d x %0d y %0d", rsp_payload.kind,
                   rsp_payload.pixel_x, rsp_payload.pixel_y);
            failures++;
         end else begin
            want = queued_writes.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_payload.kind));
            check_field("pixel_x", 32'(want.pixel_x), 32'(rsp_payload.pixel_x));
            check_field("pixel_y", 32'(want.pixel_y), 32'(rsp_payload.pixel_y));
            check_field("red", 32'(want.red), 32'(rsp_payload.red));
            check_field("green", 32'(want.green), 32'(rsp_payload.green));
            check_field("blue", 32'(want.blue), 32'(rsp_payload.blue));
            check_field("last", 32'(want.last), 32'(rsp_payload.last));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = !steady && ($urandom_range(99) < 16);
      end
   end

   // valid stays high on return; the next call or wait_for_idle moves it
   task automatic send_request(input req_type item);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      render_request(item);
   endtask

   task automatic send_char(input logic [7:0] code, input logic inv);
      send_request(build_request(CMD_PUT_CHAR, code, 3'($urandom_range(7)),
                                 8'($urandom_range(255)), inv));
   endtask

   task automatic send_newline();
      send_char(NEWLINE_CODE, 1'($urandom_range(1)));
   endtask

   task automatic load_glyph(input logic [7:0] code, input logic [63:0] rows);
      int rr;
      for (rr = 0; rr < 8; rr++)
         send_request(build_request(CMD_LOAD_ROW, code, 3'(rr), rows[8*rr +: 8],
                                    1'($urandom_range(1))));
   endtask

   function automatic logic [7:0] pick_glyph();
      logic [7:0] code;
      code = 8'($urandom_range(255));
      if (rows_loaded[code] != 8'hff)
         code = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
      return code;
   endfunction

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (queued_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [COLOR_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_SCREEN_WIDTH: cfg_width = data[12:0];
         CSR_SCREEN_HEIGHT: cfg_height = data[12:0];
         CSR_DRAW_COLOR: cfg_color = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_screen(input logic [COLOR_W-1:0] width, input logic [COLOR_W-1:0] height,
                             input logic [COLOR_W-1:0] color);
      wait_for_idle();
      write_csr(CSR_SCREEN_WIDTH, width);
      write_csr(CSR_SCREEN_HEIGHT, height);
      write_csr(CSR_DRAW_COLOR, color);
   endtask

   task automatic test_font_and_sense();
      load_glyph(8'hff, {8{8'hff}});
      load_glyph(8'h00, {4{8'h55, 8'haa}});
      send_char(8'hff, 1'b0);
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'h00, 1'b1);
   endtask

   task automatic test_newline_scroll();
      set_screen(24'd640, 24'd80, 24'($urandom_range(24'hffffff)));
      send_newline();
      send_newline();
      send_char(8'h00, 1'b0);
      send_newline();
      send_char(8'hff, 1'b0);
   endtask

   task automatic test_screen_limits();
      set_screen(24'd0, 24'd0, 24'h000000);
      send_char(8'hff, 1'b0);
      send_char(8'h00, 1'b1);
      send_newline();
      set_screen(24'hffffff, 24'd4096, 24'hffffff);
      write_csr(CSR_UNUSED, 24'($urandom_range(24'hffffff)));
      send_char(8'hff, 1'b0);
      send_char(8'h00, 1'b0);
      set_screen(24'd4096, 24'd8191, 24'($urandom_range(24'hffffff)));
      send_char(8'hff, 1'b0);
      send_newline();
   endtask

   task automatic test_narrow_screen();
      set_screen(24'd1, 24'd4096, 24'h00ff00);
      repeat (40) send_char(8'hff, 1'b1);
      send_char(8'hff, 1'b0);
      send_char(8'h00, 1'b0);
   endtask

   task automatic test_backpressure();
      set_screen(24'd640, 24'd480, 24'($urandom_range(24'hffffff)));
      hold_cycles = 400;
      repeat (10) send_char(pick_glyph(), 1'($urandom_range(1)));
   endtask

   task automatic run_random_phase(input int items);
      int sent;
      int pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            load_glyph(8'($urandom_range(255)), {$urandom, $urandom});
            sent += 8;
         end else if (pick < 27) begin
            send_request(build_request(CMD_LOAD_ROW, 8'($urandom_range(255)),
                                       3'($urandom_range(7)), 8'($urandom_range(255)),
                                       1'($urandom_range(1))));
            sent++;
         end else if (pick < 37) begin
            send_newline();
            sent++;
         end else begin
            send_char(pick_glyph(), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      set_screen(24'd640, 24'd480, 24'($urandom_range(24'hffffff)));
      run_random_phase(60);
      set_screen(24'($urandom_range(1, 64)), 24'($urandom_range(80, 200)),
                 24'($urandom_range(24'hffffff)));
      steady = 1'b1;
      run_random_phase(60);
      wait_for_idle();
      steady = 1'b0;
      set_screen(24'($urandom_range(1, 4096)), 24'($urandom_range(80, 4096)),
                 24'($urandom_range(24'hffffff)));
      run_random_phase(60);
      set_screen(24'($urandom_range(24'hffffff)), 24'($urandom_range(24'hffffff)),
                 24'($urandom_range(24'hffffff)));
      run_random_phase(60);
   endtask

   initial begin
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_wdata = '0;
      for (int g = 0; g < 256; g++)
         rows_loaded[g] = 8'h00;
      col_pos = '0;
      row_pos = '0;
      cfg_width = 13'd640;
      cfg_height = 13'd480;
      cfg_color = 24'hffffff;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_font_and_sense();
      test_newline_scroll();
      test_screen_limits();
      test_narrow_screen();
      test_backpressure();
      test_random_traffic();

      wait_for_idle();
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcgr_pkg.sv
sv/tcgr_front.sv
sv/tcgr_back.sv
sv/text_console_glyph_renderer.sv
sv/tcgr_checker.sv
dv/text_console_glyph_renderer_tb.sv
